[rtl/core/fsmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmc_pkg
// Shared widths, command codes, register indexes and result type for the
// stepper focuser motion controller.
// ----------------------------------------------------------------------------
package fsmc_pkg;

	localparam int CmdW    = 3;
	localparam int PosW    = 24;
	localparam int StepsW  = 25;
	localparam int TotalW  = 48;
	localparam int BlW     = 12;
	localparam int PeriodW = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 24;

	// Command codes
	localparam logic [CmdW-1:0] CmdTick  = 3'd0;
	localparam logic [CmdW-1:0] CmdRel   = 3'd1;
	localparam logic [CmdW-1:0] CmdAbs   = 3'd2;
	localparam logic [CmdW-1:0] CmdAbort = 3'd3;
	localparam logic [CmdW-1:0] CmdSync  = 3'd4;

	// Register indexes
	localparam logic [CfgIdxW-1:0] RegLowerLimit = 3'd0;
	localparam logic [CfgIdxW-1:0] RegUpperLimit = 3'd1;
	localparam logic [CfgIdxW-1:0] RegReverse    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegBlEnable   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegBlCount    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegStepPeriod = 3'd5;
	localparam logic [CfgIdxW-1:0] RegLinkUp     = 3'd6;

	// Last travel direction codes
	localparam logic [1:0] DirNone = 2'd0;
	localparam logic [1:0] DirOut  = 2'd1;
	localparam logic [1:0] DirIn   = 2'd2;

	typedef struct packed {
		logic                    accepted;
		logic signed [PosW-1:0]  position;
		logic                    moving;
		logic                    move_done;
		logic                    move_aborted;
		logic [TotalW-1:0]       travel_total;
	} result_t;

endpackage

[rtl/core/fsmc_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmc_cmd_if
// Command channel: one command item (cmd, amount) per handshake.
// ----------------------------------------------------------------------------
interface fsmc_cmd_if
	import fsmc_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CmdW-1:0]        cmd;
	logic signed [PosW-1:0] amount;

	modport source (output valid, output cmd, output amount, input ready);
	modport sink   (input valid, input cmd, input amount, output ready);
endinterface

[rtl/core/fsmc_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmc_res_if
// Result channel: one status item per command item.
// ----------------------------------------------------------------------------
interface fsmc_res_if
	import fsmc_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic signed [PosW-1:0] position;
	logic                   moving;
	logic                   move_done;
	logic                   move_aborted;
	logic [TotalW-1:0]      travel_total;

	modport source (output valid, output accepted, output position, output moving,
		output move_done, output move_aborted, output travel_total, input ready);
	modport sink   (input valid, input accepted, input position, input moving,
		input move_done, input move_aborted, input travel_total, output ready);
endinterface

[rtl/core/fsmc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fsmc_cfg_if
	import fsmc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/focuser_step_motion_control_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focuser_step_motion_control_top
// Stepper focuser motion controller with backlash compensation.
// ----------------------------------------------------------------------------
// Each command item (tick, relative move, absolute move, abort, sync) yields
// exactly one status item, held in the result register. The block takes one
// item per cycle sustained: the whole decision (window check, backlash, step
// and travel-total update) is one pass of adds and compares from the motion
// state registers into the result register, and the result register frees
// in the same cycle that the sink takes its item, so command.ready stays high
// unless a result is held by a stalled sink. Configuration writes are taken
// at any time (cfg.ready is always high) but must only be issued while no
// result is pending. Moves are refused while a move runs or while the link is
// down, and when the end point falls outside [max(lower_limit, MIN_TRAVEL),
// min(upper_limit, MAX_TRAVEL)]. A running move steps the position once every
// step_period ticks (zero counts as one); a zero-length move finishes on the
// next tick. Completed moves add their length to a 48-bit saturating total.
// ----------------------------------------------------------------------------
module focuser_step_motion_control_top
	import fsmc_pkg::*;
#(
	parameter int MAX_TRAVEL = 65535,
	parameter int MIN_TRAVEL = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	fsmc_cmd_if.sink   command,
	fsmc_res_if.source result,
	fsmc_cfg_if.sink   cfg
);

	localparam logic signed [PosW-1:0] MaxTravel = PosW'(MAX_TRAVEL);
	localparam logic signed [PosW-1:0] MinTravel = PosW'(MIN_TRAVEL);

	// Configuration registers
	logic signed [PosW-1:0] lower_limit_q;
	logic signed [PosW-1:0] upper_limit_q;
	logic                   reverse_q;
	logic                   bl_enable_q;
	logic [BlW-1:0]         bl_count_q;
	logic [PeriodW-1:0]     step_period_q;
	logic                   link_up_q;

	// Motion state
	logic signed [PosW-1:0] pos_q,       pos_d;
	logic [StepsW-1:0]      steps_left_q, steps_left_d;
	logic [StepsW-1:0]      move_len_q,  move_len_d;
	logic                   step_sign_q, step_sign_d;
	logic [1:0]             last_dir_q,  last_dir_d;
	logic                   busy_q,      busy_d;
	logic [PeriodW-1:0]     tick_div_q,  tick_div_d;
	logic [TotalW-1:0]      travel_q,    travel_d;

	// Result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_d;

	logic cmd_fire;
	logic cfg_fire;

	// Move planning
	logic signed [StepsW-1:0]   amt_x;
	logic signed [StepsW-1:0]   pos_x;
	logic signed [StepsW-1:0]   rel_s;
	logic signed [StepsW-1:0]   abs_s;
	logic signed [StepsW-1:0]   raw_s;
	logic                       raw_out;
	logic                       add_bl;
	logic signed [StepsW:0]     bl_s;
	logic signed [StepsW+1:0]   rel_target;
	logic signed [PosW-1:0]     win_lo;
	logic signed [PosW-1:0]     win_hi;
	logic                       rel_ok;
	logic                       abs_ok;
	logic signed [StepsW:0]     mag;

	// Tick path
	logic [PeriodW-1:0]   per_eff;
	logic [PeriodW-1:0]   tick_inc;
	logic [StepsW-1:0]    steps_dec;
	logic [TotalW:0]      travel_add;
	logic [TotalW-1:0]    travel_sat;

	assign cmd_fire = command.valid && command.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	// Free the result register whenever the sink takes it
	assign command.ready = !res_valid_q || result.ready;
	assign cfg.ready     = 1'b1;

	// ------------------------------------------------------------------
	// Configuration writes; indexes past the list are dropped
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_limit_q <= '0;
			upper_limit_q <= PosW'(65535);
			reverse_q     <= 1'b0;
			bl_enable_q   <= 1'b0;
			bl_count_q    <= '0;
			step_period_q <= PeriodW'(1);
			link_up_q     <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg.index)
				RegLowerLimit: lower_limit_q <= cfg.data[PosW-1:0];
				RegUpperLimit: upper_limit_q <= cfg.data[PosW-1:0];
				RegReverse:    reverse_q     <= cfg.data[0];
				RegBlEnable:   bl_enable_q   <= cfg.data[0];
				RegBlCount:    bl_count_q    <= cfg.data[BlW-1:0];
				RegStepPeriod: step_period_q <= cfg.data[PeriodW-1:0];
				RegLinkUp:     link_up_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Move planning: signed step count, backlash, window check
	// ------------------------------------------------------------------
	always_comb begin
		amt_x = StepsW'(command.amount);
		pos_x = StepsW'(pos_q);
		rel_s = reverse_q ? -amt_x : amt_x;
		abs_s = amt_x - pos_x;
		raw_s = (command.cmd == CmdRel) ? rel_s : abs_s;

		// New direction is outward only for a positive count
		raw_out = (raw_s > 0);
		add_bl  = bl_enable_q && (bl_count_q != '0) && (last_dir_q != DirNone)
			&& (last_dir_q != (raw_out ? DirOut : DirIn));
		if (!add_bl)
			bl_s = (StepsW+1)'(raw_s);
		else if (raw_out)
			bl_s = (StepsW+1)'(raw_s) + $signed({1'b0, (StepsW)'(bl_count_q)});
		else
			bl_s = (StepsW+1)'(raw_s) - $signed({1'b0, (StepsW)'(bl_count_q)});

		// Window is the intersection of the limits and the travel range
		win_lo = (lower_limit_q < MinTravel) ? MinTravel : lower_limit_q;
		win_hi = (upper_limit_q > MaxTravel) ? MaxTravel : upper_limit_q;

		rel_target = (StepsW+2)'(pos_q) + (StepsW+2)'(bl_s);
		rel_ok = (rel_target >= (StepsW+2)'(win_lo)) && (rel_target <= (StepsW+2)'(win_hi));
		abs_ok = (command.amount >= win_lo) && (command.amount <= win_hi);

		mag = (bl_s < 0) ? -bl_s : bl_s;
	end

	// ------------------------------------------------------------------
	// Tick arithmetic
	// ------------------------------------------------------------------
	always_comb begin
		per_eff    = (step_period_q == '0) ? PeriodW'(1) : step_period_q;
		tick_inc   = tick_div_q + PeriodW'(1);
		steps_dec  = steps_left_q - StepsW'(1);
		travel_add = {1'b0, travel_q} + (TotalW+1)'(move_len_q);
		travel_sat = travel_add[TotalW] ? {TotalW{1'b1}} : travel_add[TotalW-1:0];
	end

	// ------------------------------------------------------------------
	// Next state and result for the item at the port
	// ------------------------------------------------------------------
	always_comb begin
		pos_d        = pos_q;
		steps_left_d = steps_left_q;
		move_len_d   = move_len_q;
		step_sign_d  = step_sign_q;
		last_dir_d   = last_dir_q;
		busy_d       = busy_q;
		tick_div_d   = tick_div_q;
		travel_d     = travel_q;
		res_d        = '0;

		case (command.cmd)
			CmdTick: begin
				res_d.accepted = 1'b1;
				if (busy_q) begin
					if (steps_left_q == '0) begin
						// Zero-length move finishes here
						travel_d        = travel_sat;
						busy_d          = 1'b0;
						tick_div_d      = '0;
						res_d.move_done = 1'b1;
					end else if (tick_inc >= per_eff) begin
						tick_div_d = '0;
						if (step_sign_q) begin
							pos_d      = pos_q - PosW'(1);
							last_dir_d = DirIn;
						end else begin
							pos_d      = pos_q + PosW'(1);
							last_dir_d = DirOut;
						end
						steps_left_d = steps_dec;
						if (steps_dec == '0) begin
							travel_d        = travel_sat;
							busy_d          = 1'b0;
							res_d.move_done = 1'b1;
						end
					end else begin
						tick_div_d = tick_inc;
					end
				end
			end
			CmdRel, CmdAbs: begin
				if (!busy_q && link_up_q
					&& ((command.cmd == CmdRel) ? rel_ok : abs_ok)) begin
					steps_left_d   = mag[StepsW-1:0];
					move_len_d     = mag[StepsW-1:0];
					step_sign_d    = !(bl_s > 0);
					tick_div_d     = '0;
					busy_d         = 1'b1;
					res_d.accepted = 1'b1;
				end
			end
			CmdAbort: begin
				// Stop without crediting the travel total
				if (busy_q) begin
					busy_d             = 1'b0;
					steps_left_d       = '0;
					tick_div_d         = '0;
					res_d.accepted     = 1'b1;
					res_d.move_aborted = 1'b1;
				end
			end
			CmdSync: begin
				if (!busy_q) begin
					pos_d          = command.amount;
					res_d.accepted = 1'b1;
				end
			end
			default: ;
		endcase

		res_d.position     = pos_d;
		res_d.moving       = busy_d;
		res_d.travel_total = travel_d;
	end

	// ------------------------------------------------------------------
	// State and result registers; advance only on an accepted item
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			steps_left_q <= '0;
			move_len_q   <= '0;
			step_sign_q  <= 1'b0;
			last_dir_q   <= DirNone;
			busy_q       <= 1'b0;
			tick_div_q   <= '0;
			travel_q     <= '0;
		end else if (cmd_fire) begin
			pos_q        <= pos_d;
			steps_left_q <= steps_left_d;
			move_len_q   <= move_len_d;
			step_sign_q  <= step_sign_d;
			last_dir_q   <= last_dir_d;
			busy_q       <= busy_d;
			tick_div_q   <= tick_div_d;
			travel_q     <= travel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.accepted     = res_q.accepted;
	assign result.position     = res_q.position;
	assign result.moving       = res_q.moving;
	assign result.move_done    = res_q.move_done;
	assign result.move_aborted = res_q.move_aborted;
	assign result.travel_total = res_q.travel_total;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (steps_left_q == '0) && (tick_div_q == '0))
		else $error("idle with steps or divider left over");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && res_d.move_done |=> !busy_q && res_valid_q && !res_q.moving)
		else $error("completed move still marked busy");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> travel_q >= $past(travel_q))
		else $error("travel total decreased");

	a_res_mirrors: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (res_q.position == pos_q) && (res_q.moving == busy_q)
			&& (res_q.travel_total == travel_q))
		else $error("result disagrees with state after item");

endmodule
